@@ rtl/b64lw_pkg.sv @@
// Types, constants and the character table for the line-wrapped base64 encoder.
// Used by every module under rtl; depends on nothing.
package b64lw_pkg;

  localparam int unsigned MAX_CHARS = 6;

  localparam logic [7:0] CHAR_PAD = 8'h2d;  // '-'
  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;

  localparam logic [0:63][7:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789._";

  typedef enum logic [1:0] {
    PHASE_FIRST,
    PHASE_SECOND,
    PHASE_THIRD
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       message_end;
  } out_item_t;

  typedef struct packed {
    phase_e     group_phase;
    logic [3:0] leftover_bits;
    logic [3:0] groups_on_line;
  } enc_state_t;

  // All characters caused by one byte, first character in slot 0.
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                count;
    logic                      fin;
  } burst_t;

  function automatic logic [7:0] enc6(input logic [5:0] v);
    return B64_ALPHABET[v];
  endfunction

endpackage

@@ rtl/b64lw_expand.sv @@
// Combinational encode of one byte into its burst of characters and the next state.
// Depends on b64lw_pkg.
module b64lw_expand import b64lw_pkg::*; #(
  parameter int GROUPS_PER_LINE = 15
) (
  input  in_item_t   item_i,
  input  enc_state_t state_i,
  output burst_t     burst_o,
  output enc_state_t state_o
);

  localparam logic [3:0] GplW = 4'(GROUPS_PER_LINE);

  logic [7:0] b;
  logic       fin;
  logic       group_done;
  logic [2:0] n;
  logic [3:0] line_cnt;
  logic       wrap;

  assign b   = item_i.data_byte;
  assign fin = item_i.final_byte;

  always_comb begin
    burst_o    = '0;
    state_o    = state_i;
    group_done = 1'b0;
    n          = 3'd1;
    case (state_i.group_phase)
      PHASE_SECOND: begin
        burst_o.chars[0]      = enc6({state_i.leftover_bits[1:0], b[7:4]});
        state_o.leftover_bits = b[3:0];
        state_o.group_phase   = PHASE_THIRD;
        if (fin) begin
          burst_o.chars[1] = enc6({b[3:0], 2'b00});
          burst_o.chars[2] = CHAR_PAD;
          n                = 3'd3;
          group_done       = 1'b1;
        end
      end
      PHASE_THIRD: begin
        burst_o.chars[0]      = enc6({state_i.leftover_bits, b[7:6]});
        burst_o.chars[1]      = enc6(b[5:0]);
        n                     = 3'd2;
        state_o.leftover_bits = 4'd0;
        state_o.group_phase   = PHASE_FIRST;
        group_done            = 1'b1;
      end
      default: begin
        burst_o.chars[0]      = enc6(b[7:2]);
        state_o.leftover_bits = {2'b00, b[1:0]};
        state_o.group_phase   = PHASE_SECOND;
        if (fin) begin
          burst_o.chars[1] = enc6({b[1:0], 4'b0000});
          burst_o.chars[2] = CHAR_PAD;
          burst_o.chars[3] = CHAR_PAD;
          n                = 3'd4;
          group_done       = 1'b1;
        end
      end
    endcase

    line_cnt = state_i.groups_on_line + 4'd1;
    wrap     = group_done && (line_cnt >= GplW);
    if (group_done) begin
      state_o.groups_on_line = wrap ? 4'd0 : line_cnt;
    end
    // Append CR LF right after the group's characters.
    if (wrap) begin
      for (int i = 0; i < MAX_CHARS; i++) begin
        if (3'(i) == n)        burst_o.chars[i] = CHAR_CR;
        if (3'(i) == n + 3'd1) burst_o.chars[i] = CHAR_LF;
      end
    end
    burst_o.count = wrap ? n + 3'd2 : n;
    burst_o.fin   = fin;

    // A final byte closes the message: the next one starts a new group with the line count cleared.
    if (fin) begin
      state_o.group_phase    = PHASE_FIRST;
      state_o.leftover_bits  = 4'd0;
      state_o.groups_on_line = 4'd0;
    end
  end

endmodule

@@ rtl/b64lw_serializer.sv @@
// Result register: holds one burst of characters and shifts out one per beat.
// Depends on b64lw_pkg.
module b64lw_serializer import b64lw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  burst_t    burst_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [MAX_CHARS-1:0][7:0] chars_q, chars_d;
  logic [2:0]                count_q, count_d;
  logic                      fin_q, fin_d;
  logic                      out_accept;
  logic                      last_char;

  assign out_valid_o = (count_q != 3'd0);
  assign out_accept  = out_valid_o && !out_stall_i;
  assign last_char   = (count_q == 3'd1);
  assign ready_o     = !out_valid_o || (out_accept && last_char);

  assign out_item_o.out_char    = chars_q[0];
  assign out_item_o.run_last    = last_char;
  assign out_item_o.message_end = last_char && fin_q;

  always_comb begin
    chars_d = chars_q;
    count_d = count_q;
    fin_d   = fin_q;
    if (load_i) begin
      chars_d = burst_i.chars;
      count_d = burst_i.count;
      fin_d   = burst_i.fin;
    end else if (out_accept) begin
      // Advance to the next character of the burst.
      for (int i = 0; i < MAX_CHARS - 1; i++) begin
        chars_d[i] = chars_q[i+1];
      end
      chars_d[MAX_CHARS-1] = 8'd0;
      count_d              = count_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 3'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
    fin_q   <= fin_d;
  end

endmodule

@@ rtl/base64_line_wrapped_encoder_top.sv @@
// Top level of the line-wrapped base64 encoder: input register, encoder state, result shifter.
// Depends on b64lw_pkg, b64lw_expand and b64lw_serializer.
//
// Each accepted byte yields 1 to 6 characters (alphabet A-Z a-z 0-9 . _, pad '-', CR LF after
// every GROUPS_PER_LINE groups), delivered one per cycle from the result shifter while
// out_stall_i is low: 1 or 2 for a middle byte and up to 4 for a final byte, plus 2 for a
// line break.
// The input register takes the next byte while the current burst drains, and the byte is
// encoded in the cycle its predecessor's last character leaves. An accepted byte passes through
// the input register and then the result register before its first character appears.
module base64_line_wrapped_encoder_top import b64lw_pkg::*; #(
  parameter int GROUPS_PER_LINE = 15
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [3:0] GplW = 4'(GROUPS_PER_LINE);

  in_item_t   in_q;
  logic       in_valid_q, in_valid_d;
  enc_state_t state_q, state_d;
  burst_t     burst;
  logic       ser_ready;
  logic       load;
  logic       in_accept;

  assign load       = in_valid_q && ser_ready;
  assign in_stall_o = in_valid_q && !load;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  b64lw_expand #(
    .GROUPS_PER_LINE(GROUPS_PER_LINE)
  ) u_expand (
    .item_i (in_q),
    .state_i(state_q),
    .burst_o(burst),
    .state_o(state_d)
  );

  b64lw_serializer u_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .burst_i    (burst),
    .ready_o    (ser_ready),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= '{group_phase: PHASE_FIRST, leftover_bits: 4'd0, groups_on_line: 4'd0};
    end else begin
      in_valid_q <= in_valid_d;
      if (load) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_item_i;
    end
  end

  a_line_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.groups_on_line < GplW)
    else $error("groups_on_line reached the line length");

  a_final_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && in_q.final_byte |=>
      state_q.group_phase == PHASE_FIRST && state_q.leftover_bits == 4'd0 &&
      state_q.groups_on_line == 4'd0)
    else $error("final byte did not clear the encoder state");

  a_message_end_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.message_end |-> out_item_o.run_last)
    else $error("message_end on a character that is not the last of its byte");

  a_load_needs_free_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && out_valid_o |-> !out_stall_i && out_item_o.run_last)
    else $error("burst loaded over characters not yet delivered");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for base64_line_wrapped_encoder_top: directed and random messages.
// Predicts every character in place; depends on b64lw_pkg and the RTL under rtl.
module testbench;
  import b64lw_pkg::*;

  localparam int GROUPS_PER_LINE = 15;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int END_HOLDOFF     = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  base64_line_wrapped_encoder_top #(
    .GROUPS_PER_LINE(GROUPS_PER_LINE)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Encoder state as predicted
  phase_e     enc_phase = PHASE_FIRST;
  logic [3:0] enc_leftover = '0;
  logic [3:0] enc_groups = '0;

  out_item_t expected_chars[$];
  out_item_t want;
  int        fail_count = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + {2'b00, v};
    else if (v < 6'd52) return 8'h61 + {2'b00, v - 6'd26};
    else if (v < 6'd62) return 8'h30 + {2'b00, v - 6'd52};
    else if (v == 6'd62) return 8'h2e;
    else return 8'h5f;
  endfunction

  function automatic void predict_chars(input logic [7:0] b, input logic fin);
    logic [7:0] burst[$];
    logic       group_done;
    out_item_t  exp;
    group_done = 1'b0;
    case (enc_phase)
      PHASE_SECOND: begin
        burst.push_back(b64_char({enc_leftover[1:0], b[7:4]}));
        enc_leftover = b[3:0];
        enc_phase = PHASE_THIRD;
        if (fin) begin
          burst.push_back(b64_char({b[3:0], 2'b00}));
          burst.push_back(CHAR_PAD);
          group_done = 1'b1;
        end
      end
      PHASE_THIRD: begin
        burst.push_back(b64_char({enc_leftover, b[7:6]}));
        burst.push_back(b64_char(b[5:0]));
        enc_leftover = '0;
        enc_phase = PHASE_FIRST;
        group_done = 1'b1;
      end
      default: begin
        burst.push_back(b64_char(b[7:2]));
        enc_leftover = {2'b00, b[1:0]};
        enc_phase = PHASE_SECOND;
        if (fin) begin
          burst.push_back(b64_char({b[1:0], 4'b0000}));
          burst.push_back(CHAR_PAD);
          burst.push_back(CHAR_PAD);
          group_done = 1'b1;
        end
      end
    endcase
    if (group_done) begin
      enc_groups = enc_groups + 4'd1;
      if (enc_groups >= GROUPS_PER_LINE) begin
        enc_groups = '0;
        burst.push_back(CHAR_CR);
        burst.push_back(CHAR_LF);
      end
    end
    if (fin) begin
      enc_phase = PHASE_FIRST;
      enc_leftover = '0;
      enc_groups = '0;
    end
    foreach (burst[i]) begin
      exp.out_char    = burst[i];
      exp.run_last    = (i == burst.size() - 1);
      exp.message_end = fin && (i == burst.size() - 1);
      expected_chars.push_back(exp);
    end
  endfunction

  // Enter at a falling edge; return at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_item_t item;
    item.data_byte  = b;
    item.final_byte = fin;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_chars(b, fin);
    @(negedge clk_i);
  endtask

  task automatic send_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom_range(255));
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // Hold the input low until every predicted character has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic test_one_byte_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'haa, 1'b1);
    send_byte(8'h55, 1'b1);
  endtask

  task automatic test_two_byte_messages();
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_full_groups();
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);
    // symbol 62 of the alphabet, '.', in all four positions
    send_byte(8'hfb, 1'b0);
    send_byte(8'hef, 1'b0);
    send_byte(8'hbe, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h83, 1'b1);
  endtask

  // Message lengths whose final group closes the line, so CR LF ends the message.
  task automatic test_line_wrap_at_end();
    for (int len = 3 * GROUPS_PER_LINE - 2; len <= 3 * GROUPS_PER_LINE; len++)
      send_message(len);
  endtask

  task automatic test_random_messages(input int num_items);
    int sent;
    int len;
    int k;
    sent = 0;
    while (sent < num_items) begin
      case ($urandom_range(9))
        0: len = $urandom_range(3, 1);
        1: begin
          k   = $urandom_range(2, 1);
          len = 3 * GROUPS_PER_LINE * k - $urandom_range(2);
        end
        2: len = $urandom_range(100, 51);
        default: len = $urandom_range(50, 1);
      endcase
      send_message(len);
      sent += len;
    end
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (END_HOLDOFF) @(posedge clk_i);
    if (expected_chars.size() != 0) begin
      $display("%0t: %0d characters never came out", $time, expected_chars.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, out_item_o);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_item_o.out_char !== want.out_char) begin
          $display("%0t: out_char expected %h, actual %h",
                   $time, want.out_char, out_item_o.out_char);
          fail_count++;
        end
        if (out_item_o.run_last !== want.run_last) begin
          $display("%0t: run_last expected %b, actual %b",
                   $time, want.run_last, out_item_o.run_last);
          fail_count++;
        end
        if (out_item_o.message_end !== want.message_end) begin
          $display("%0t: message_end expected %b, actual %b",
                   $time, want.message_end, out_item_o.message_end);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 34;
    recv_idle_pct = 82;
    test_one_byte_messages();
    test_two_byte_messages();
    test_full_groups();
    test_random_messages(60);

    send_idle_pct = 82;
    recv_idle_pct = 34;
    test_line_wrap_at_end();
    test_random_messages(60);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_messages(60);
    finish_run();
  end

endmodule
